FILE: hdl/nlmsnc_pkg.sv
// ---------------------------------------------------------------------------
// nlmsnc_pkg
// Shared constants, register indexes and the sequencer state type of the
// adaptive noise canceller.
// ---------------------------------------------------------------------------
`default_nettype none

package nlmsnc_pkg;

   // Default sizes of the storage.
   localparam int NLMS_MAX_TAPS     = 256;
   localparam int NLMS_MAX_CHANNELS = 2;
   localparam int NLMS_MAX_NOISES   = 4;

   // Fixed field widths.
   localparam int SAMPLE_W   = 16;
   localparam int WEIGHT_W   = 32;
   localparam int GAIN_W     = 16;
   localparam int TAPCNT_W   = 9;
   localparam int CHCNT_W    = 2;
   localparam int NCNT_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_GAIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STRENGTH      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_COUNT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_COUNT   = 3'd4;

   // Arithmetic constants.
   localparam logic [GAIN_W-1:0] GAIN_LIMIT   = 16'd32768;
   localparam logic [GAIN_W-1:0] CANCEL_LIMIT = 16'd24576;
   localparam int                MIN_TAPS     = 8;
   localparam int                ENERGY_EPS   = 1074;
   localparam int                STEP_W       = 49;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_REF,
      S_PASS1,
      S_ERR,
      S_MUL,
      S_DIV,
      S_PASS2,
      S_OUT1,
      S_OUT2
   } nlms_state_type;

endpackage

`default_nettype wire

FILE: hdl/nlmsnc_if.sv
// ---------------------------------------------------------------------------
// nlmsnc_if
// Valid/ready channels of the noise canceller: sample beats in, cleaned
// sample beats out.
// ---------------------------------------------------------------------------
`default_nettype none

interface nlmsnc_req_if import nlmsnc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] desired_sample;
   logic signed [SAMPLE_W-1:0] noise_a;
   logic signed [SAMPLE_W-1:0] noise_b;
   logic signed [SAMPLE_W-1:0] noise_c;
   logic signed [SAMPLE_W-1:0] noise_d;

   modport source (output valid, desired_sample, noise_a, noise_b, noise_c, noise_d,
                   input ready);
   modport sink   (input valid, desired_sample, noise_a, noise_b, noise_c, noise_d,
                   output ready);
endinterface

interface nlmsnc_rsp_if import nlmsnc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] cleaned_sample;
   logic                       sample_channel;

   modport source (output valid, cleaned_sample, sample_channel, input ready);
   modport sink   (input valid, cleaned_sample, sample_channel, output ready);
endinterface

`default_nettype wire

FILE: hdl/nlmsnc_ram.sv
// ---------------------------------------------------------------------------
// nlmsnc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module nlmsnc_ram #(
   parameter int Width = 32,
   parameter int Depth = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output      logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_q [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_q[wr_addr] <= wr_data;
      end
      rd_data <= mem_q[rd_addr];
   end

endmodule

`default_nettype wire

FILE: hdl/nlmsnc_div.sv
// ---------------------------------------------------------------------------
// nlmsnc_div
// Radix-2 restoring divider, signed numerator over positive denominator,
// quotient rounded towards minus infinity. One quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module nlmsnc_div #(
   parameter int NumW = 64,
   parameter int DenW = 40
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic signed [NumW-1:0] numer,
   input  wire logic [DenW-1:0]        denom,
   output      logic                   done,
   output      logic signed [NumW-1:0] quot
);

   localparam int CNT_W = $clog2(NumW + 1);

   logic [NumW-1:0]  mag_ff, mag_in;
   logic [DenW-1:0]  rem_ff, rem_in;
   logic [DenW-1:0]  den_ff;
   logic             neg_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [DenW:0]    rem_sh;

   always_comb begin
      rem_sh = {rem_ff, mag_ff[NumW-1]};
      if (rem_sh >= {1'b0, den_ff}) begin
         rem_in = DenW'(rem_sh - {1'b0, den_ff});
         mag_in = {mag_ff[NumW-2:0], 1'b1};
      end else begin
         rem_in = rem_sh[DenW-1:0];
         mag_in = {mag_ff[NumW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NumW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mag_ff <= numer[NumW-1] ? unsigned'(-numer) : unsigned'(numer);
         neg_ff <= numer[NumW-1];
         den_ff <= denom;
         rem_ff <= '0;
      end else if (busy_ff) begin
         mag_ff <= mag_in;
         rem_ff <= rem_in;
      end
   end

   // A negative quotient with a remainder steps one further down: -(q+1) = ~q.
   always_comb begin
      if (!neg_ff) begin
         quot = signed'(mag_ff);
      end else if (rem_ff != '0) begin
         quot = signed'(~mag_ff);
      end else begin
         quot = -signed'(mag_ff);
      end
   end

   assign done = done_ff;

endmodule

`default_nettype wire

FILE: hdl/nlms_noise_canceller.sv
// ---------------------------------------------------------------------------
// nlms_noise_canceller
// Adaptive NLMS noise canceller for interleaved audio, with weights and
// reference history held in two synchronous RAMs.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake     Payload
//  req_ch    in         valid/ready   desired_sample, noise_a .. noise_d
//  rsp_ch    out        valid/ready   cleaned_sample, sample_channel
//  csr_*     in         write enable  csr_index, csr_wdata (no read-back)
//
// One sample beat is taken at a time, in the idle state. With filtering on, a
// beat runs through the reference average in the shared divider, the
// prediction pass, the error, the step product and the step division, the
// weight pass and the output states. A beat with low window energy skips
// the error, the division and the weight pass; in bypass (strength zero) a
// beat goes from the idle state straight to the output states. The two serial
// divisions and the two passes over the RAM read ports take most of the time
// of a beat.
// After reset a clearing pass writes zero to every RAM entry; no sample beat
// is accepted meanwhile, configuration writes are taken as ever.
// The result sits in an output register, so a stalled rsp_ch does not stop
// the next sample beat from being accepted and processed; only the final
// hand-over waits for the output register to be free.
//
`default_nettype none

module nlms_noise_canceller import nlmsnc_pkg::*; #(
   parameter int MaxTaps     = NLMS_MAX_TAPS,
   parameter int MaxChannels = NLMS_MAX_CHANNELS,
   parameter int MaxNoises   = NLMS_MAX_NOISES
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   nlmsnc_req_if.sink                 req_ch,
   nlmsnc_rsp_if.source               rsp_ch
);

   // Storage geometry: each channel owns MaxTaps consecutive RAM entries.
   localparam int DEPTH  = MaxChannels * MaxTaps;
   localparam int AW     = $clog2(DEPTH);
   localparam int IDX_W  = $clog2(MaxTaps);
   localparam int CNT_W  = $clog2(MaxTaps + 1);
   localparam int CH_W   = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
   // Prediction sum of MaxTaps Q4.28 x Q1.15 products, energy of MaxTaps squares.
   localparam int ACC_W  = 47 + $clog2(MaxTaps) + 1;
   localparam int EN_W   = 31 + $clog2(MaxTaps) + 1;
   localparam int P28_W  = ACC_W - 15;
   localparam int NUM_W  = 64;

   localparam logic signed [NUM_W-1:0] STEP_HI = NUM_W'(64'sd1 <<< 47);
   localparam logic signed [NUM_W-1:0] STEP_LO = -STEP_HI;
   localparam logic signed [63:0]      I32_HI  = 64'sd2147483647;
   localparam logic signed [63:0]      I32_LO  = -64'sd2147483648;

   // Configuration registers.
   logic [GAIN_W-1:0]   gain_ff;
   logic [GAIN_W-1:0]   strength_ff;
   logic [TAPCNT_W-1:0] taps_ff;
   logic [CHCNT_W-1:0]  chans_ff;
   logic [NCNT_W-1:0]   noises_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff     <= GAIN_W'(16384);
         strength_ff <= GAIN_W'(16384);
         taps_ff     <= TAPCNT_W'(256);
         chans_ff    <= CHCNT_W'(1);
         noises_ff   <= NCNT_W'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SOURCE_GAIN:   gain_ff     <= csr_wdata;
            CSR_STRENGTH:      strength_ff <= csr_wdata;
            CSR_TAP_COUNT:     taps_ff     <= csr_wdata[TAPCNT_W-1:0];
            CSR_CHANNEL_COUNT: chans_ff    <= csr_wdata[CHCNT_W-1:0];
            CSR_NOISE_COUNT:   noises_ff   <= csr_wdata[NCNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamped settings. Strength above 32768 acts as 32768, so the NLMS rate
   // min(1, s/4) in Q0.16 equals s itself; the cancel factor is min(1.5, s).
   logic [GAIN_W-1:0] g_q, s_q, c_q;
   logic [CNT_W-1:0]  l_q;
   int                lv, chans_q, n_q;

   always_comb begin
      g_q = (gain_ff > GAIN_LIMIT) ? GAIN_LIMIT : gain_ff;
      s_q = (strength_ff > GAIN_LIMIT) ? GAIN_LIMIT : strength_ff;
      c_q = (s_q > CANCEL_LIMIT) ? CANCEL_LIMIT : s_q;
      lv  = int'(taps_ff);
      if (lv < MIN_TAPS) lv = MIN_TAPS;
      if (lv > MaxTaps) lv = MaxTaps;
      l_q = CNT_W'(lv);
      chans_q = int'(chans_ff);
      if (chans_q < 1) chans_q = 1;
      if (chans_q > MaxChannels) chans_q = MaxChannels;
      n_q = int'(noises_ff);
      if (n_q < 1) n_q = 1;
      if (n_q > MaxNoises) n_q = MaxNoises;
   end

   // Sequencer and datapath registers.
   nlms_state_type state_ff, state_in;

   logic [CH_W-1:0]  ptr_ff;
   logic [IDX_W-1:0] rhead_ff [MaxChannels];
   logic [AW-1:0]    clr_ff;

   logic signed [SAMPLE_W-1:0] d_ff;
   logic [CH_W-1:0]            ch_ff;
   logic [AW-1:0]              base_ff;
   logic [IDX_W-1:0]           hd_ff;
   logic                       byp_ff;

   logic [CNT_W-1:0] k_ff, k1_ff, k2_ff;
   logic             v1_ff, v2_ff;

   logic signed [ACC_W-1:0]      acc_ff;
   logic [EN_W-1:0]              en_ff;
   logic signed [47:0]           pw_ff;
   logic [2*SAMPLE_W-1:0]        sq_ff;
   logic signed [WEIGHT_W-1:0]   e20_ff;
   logic signed [STEP_W-1:0]     step_ff;
   logic signed [STEP_W+15:0]    upd_ff;
   logic signed [WEIGHT_W-1:0]   w1_ff;
   logic signed [2*SAMPLE_W:0]   dg_ff;
   logic signed [P28_W+16:0]     cp_ff;

   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic                       rsp_chan_ff;

   // Beat-level decisions taken at acceptance.
   logic             accept;
   logic [CH_W-1:0]  ch_sel, ptr_next;
   logic [IDX_W-1:0] head_sel, head_next;
   logic signed [SAMPLE_W+2:0] nsum;
   logic signed [SAMPLE_W-1:0] noises [4];

   assign noises[0] = req_ch.noise_a;
   assign noises[1] = req_ch.noise_b;
   assign noises[2] = req_ch.noise_c;
   assign noises[3] = req_ch.noise_d;

   always_comb begin
      ch_sel    = (int'(ptr_ff) >= chans_q) ? '0 : ptr_ff;
      ptr_next  = (int'(ch_sel) + 1 >= chans_q) ? '0 : CH_W'(int'(ch_sel) + 1);
      head_sel  = (CNT_W'(rhead_ff[ch_sel]) >= l_q) ? '0 : rhead_ff[ch_sel];
      head_next = (CNT_W'(head_sel) + 1'b1 >= l_q) ? '0 : head_sel + 1'b1;
      nsum = '0;
      for (int j = 0; j < 4; j++) begin
         if (j < n_q) nsum = nsum + (SAMPLE_W + 3)'(noises[j]);
      end
   end

   // Ring position of tap k: newest entry at the head, older ones behind it.
   logic [CNT_W:0]   hx, kx;
   logic [IDX_W-1:0] tap_idx;

   always_comb begin
      hx = (CNT_W + 1)'(hd_ff);
      kx = (CNT_W + 1)'(k_ff);
      if (hx >= kx) tap_idx = IDX_W'(hx - kx);
      else          tap_idx = IDX_W'(hx + (CNT_W + 1)'(l_q) - kx);
   end

   // RAMs and divider.
   logic                      w_we, h_we;
   logic [AW-1:0]             w_wa, h_wa, w_ra, h_ra;
   logic [WEIGHT_W-1:0]       w_wd, w_rd;
   logic [SAMPLE_W-1:0]       h_wd, h_rd;
   logic                      div_start, div_done;
   logic signed [NUM_W-1:0]   div_num, div_quot;
   logic [EN_W-1:0]           div_den;

   nlmsnc_ram #(.Width(WEIGHT_W), .Depth(DEPTH)) u_weights (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (w_wa),
      .wr_data (w_wd),
      .rd_addr (w_ra),
      .rd_data (w_rd)
   );

   nlmsnc_ram #(.Width(SAMPLE_W), .Depth(DEPTH)) u_history (
      .clock   (clock),
      .wr_en   (h_we),
      .wr_addr (h_wa),
      .wr_data (h_wd),
      .rd_addr (h_ra),
      .rd_data (h_rd)
   );

   nlmsnc_div #(.NumW(NUM_W), .DenW(EN_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Pass bookkeeping: a pass issues one tap a cycle and ends once the
   // two-stage read/multiply pipeline has drained.
   logic in_pass, issue, pass_done;

   assign in_pass   = (state_ff == S_PASS1) || (state_ff == S_PASS2);
   assign issue     = in_pass && (k_ff < l_q);
   assign pass_done = (k_ff >= l_q) && !v1_ff && !v2_ff;
   assign accept    = req_ch.valid && req_ch.ready;

   // Error, step numerator, updated weight and output arithmetic.
   logic signed [63:0]          err_q, e_q, nw_q, v_q, y_q;
   logic signed [WEIGHT_W+16:0] re_q;
   logic signed [P28_W-1:0]     p28_q;
   logic                        out_free;

   always_comb begin
      err_q = (64'(d_ff) <<< 28) - 64'(acc_ff);
      e_q   = err_q >>> 23;
      if (e_q > I32_HI) e_q = I32_HI;
      if (e_q < I32_LO) e_q = I32_LO;
      re_q  = signed'({1'b0, s_q}) * e20_ff;
      nw_q  = 64'(w1_ff) + 64'(upd_ff >>> 9);
      if (nw_q > I32_HI) nw_q = I32_HI;
      if (nw_q < I32_LO) nw_q = I32_LO;
      p28_q = P28_W'(acc_ff >>> 15);
      if (byp_ff) begin
         v_q = 64'(dg_ff) + 64'sd8192;
         y_q = v_q >>> 14;
      end else begin
         v_q = (64'(dg_ff) <<< 13) - 64'(cp_ff) + (64'sd1 <<< 26);
         y_q = v_q >>> 27;
      end
      if (y_q > 64'sd32767) y_q = 64'sd32767;
      if (y_q < -64'sd32768) y_q = -64'sd32768;
   end

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (clr_ff == AW'(DEPTH - 1)) state_in = S_IDLE;
         S_IDLE:  if (accept) state_in = (s_q == '0) ? S_OUT1 : S_REF;
         S_REF:   if (div_done) state_in = S_PASS1;
         S_PASS1: begin
            if (pass_done) begin
               state_in = (en_ff >= EN_W'(ENERGY_EPS)) ? S_ERR : S_OUT1;
            end
         end
         S_ERR:   state_in = S_MUL;
         S_MUL:   state_in = S_DIV;
         S_DIV:   if (div_done) state_in = S_PASS2;
         S_PASS2: if (pass_done) state_in = S_OUT1;
         S_OUT1:  state_in = S_OUT2;
         S_OUT2:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Control outputs: handshake, RAM ports and divider operands.
   always_comb begin
      req_ch.ready = 1'b0;
      div_start    = 1'b0;
      div_num      = (64'(nsum) <<< 1) + 64'(n_q);
      div_den      = EN_W'(2 * n_q);
      w_we = 1'b0;
      w_wa = base_ff + AW'(k2_ff);
      w_wd = unsigned'(WEIGHT_W'(nw_q));
      h_we = 1'b0;
      h_wa = base_ff + AW'(hd_ff);
      h_wd = unsigned'(SAMPLE_W'(div_quot));
      w_ra = base_ff + AW'(k_ff);
      h_ra = base_ff + AW'(tap_idx);
      unique case (state_ff)
         S_CLEAR: begin
            w_we = 1'b1;
            w_wa = clr_ff;
            w_wd = '0;
            h_we = 1'b1;
            h_wa = clr_ff;
            h_wd = '0;
         end
         S_IDLE: begin
            req_ch.ready = 1'b1;
            div_start    = accept && (s_q != '0);
         end
         S_REF:   h_we = div_done;
         S_MUL: begin
            div_start = 1'b1;
            div_num   = 64'(re_q) <<< 16;
            div_den   = en_ff + EN_W'(ENERGY_EPS);
         end
         S_PASS2: w_we = v2_ff;
         default: ;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         k_ff         <= '0;
         for (int c = 0; c < MaxChannels; c++) rhead_ff[c] <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (accept) begin
            ptr_ff <= ptr_next;
            if (s_q != '0) rhead_ff[ch_sel] <= head_next;
         end
         if (in_pass) begin
            if (issue) k_ff <= k_ff + 1'b1;
            v1_ff <= issue;
            v2_ff <= v1_ff;
         end else begin
            k_ff  <= '0;
            v1_ff <= 1'b0;
            v2_ff <= 1'b0;
         end
         // A new result takes the output register as the old one leaves it.
         if (state_ff == S_OUT2 && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready)              rsp_valid_ff <= 1'b0;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      if (accept) begin
         d_ff    <= req_ch.desired_sample;
         ch_ff   <= ch_sel;
         base_ff <= AW'(int'(ch_sel) * MaxTaps);
         hd_ff   <= head_sel;
         byp_ff  <= (s_q == '0);
         acc_ff  <= '0;
         en_ff   <= '0;
      end
      k1_ff <= k_ff;
      k2_ff <= k1_ff;
      if (state_ff == S_PASS1) begin
         if (v1_ff) begin
            pw_ff <= signed'(w_rd) * signed'(h_rd);
            sq_ff <= unsigned'(32'(signed'(h_rd) * signed'(h_rd)));
         end
         if (v2_ff) begin
            acc_ff <= acc_ff + ACC_W'(pw_ff);
            en_ff  <= en_ff + EN_W'(sq_ff);
         end
      end
      if (state_ff == S_PASS2 && v1_ff) begin
         upd_ff <= step_ff * signed'(h_rd);
         w1_ff  <= signed'(w_rd);
      end
      if (state_ff == S_ERR) e20_ff <= WEIGHT_W'(e_q);
      if (state_ff == S_DIV && div_done) begin
         if (div_quot > STEP_HI)      step_ff <= STEP_W'(STEP_HI);
         else if (div_quot < STEP_LO) step_ff <= STEP_W'(STEP_LO);
         else                         step_ff <= STEP_W'(div_quot);
      end
      if (state_ff == S_OUT1) begin
         dg_ff <= d_ff * signed'({1'b0, g_q});
         cp_ff <= signed'({1'b0, c_q}) * p28_q;
      end
      if (state_ff == S_OUT2 && out_free) begin
         rsp_sample_ff <= SAMPLE_W'(y_q);
         rsp_chan_ff   <= ch_ff[0];
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.cleaned_sample = rsp_sample_ff;
   assign rsp_ch.sample_channel = rsp_chan_ff;

   // Weights are written only by the clearing pass and the update pass.
   a_weight_write: assert property (@(posedge clock) disable iff (reset)
      w_we |-> (state_ff == S_CLEAR) || (state_ff == S_PASS2))
      else $error("weight RAM written outside the update pass");

   // History is written only by the clearing pass and the reference store.
   a_hist_write: assert property (@(posedge clock) disable iff (reset)
      h_we |-> (state_ff == S_CLEAR) || (state_ff == S_REF))
      else $error("history RAM written outside the reference store");

   // An accepted beat leaves the idle state in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("sequencer stayed idle after accepting a beat");

   // No result appears while the RAMs are still being cleared.
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid_ff)
      else $error("result presented during the clearing pass");

   // A weight pass only follows a window energy at or above the threshold.
   a_update_gate: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == S_PASS2) |-> en_ff >= EN_W'(ENERGY_EPS))
      else $error("weight update started on a low-energy window");

endmodule

`default_nettype wire

FILE: tb/tb_nlms_noise_canceller.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_nlms_noise_canceller
// Self-checking bench for the adaptive noise canceller: a directed table,
// then random phases under random register settings, scored against a
// bit-exact behavioural model or, for some directed rows, hand-written values.
// ---------------------------------------------------------------------------

module tb_nlms_noise_canceller import nlmsnc_pkg::*; ();

   localparam int  TAPS_MAX     = NLMS_MAX_TAPS;
   localparam int  WATCHDOG_MAX = 20000;
   localparam int  HOLD_CYCLES  = 2500;
   localparam int  PHASE_COUNT  = 8;
   localparam int  PHASE_BEATS  = 48;
   // Indexes with no register behind them; writes there must be ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam longint I32_MAX   = 64'sd2147483647;
   localparam longint I32_MIN   = -64'sd2147483648;
   localparam longint STEP_CLIP = 64'sd1 <<< 47;

   typedef struct {
      logic signed [SAMPLE_W-1:0] cleaned;
      logic                       channel;
   } cleaned_beat_type;

   typedef enum {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type               kind;
      logic [CSR_IDX_W-1:0]       index;
      logic [CSR_DATA_W-1:0]      value;
      logic signed [SAMPLE_W-1:0] fields [5];
      bit                         typed;
      cleaned_beat_type           want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   nlmsnc_req_if req_bus ();
   nlmsnc_rsp_if rsp_bus ();

   nlms_noise_canceller u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Behavioural model of the canceller: register copies and the filter state.
   // -------------------------------------------------------------------------
   logic [15:0] mdl_gain, mdl_strength;
   logic [8:0]  mdl_taps;
   logic [1:0]  mdl_channels;
   logic [2:0]  mdl_noises;
   longint      mdl_weight [2*TAPS_MAX];
   longint      mdl_history [2*TAPS_MAX];
   int          mdl_head [2];
   int          mdl_next_channel;

   cleaned_beat_type cleaned_queue [$];
   int errors = 0;
   int beats_checked = 0;
   int settings_used = 0;
   bit hold_request = 1'b0;

   // Floor division for a positive divisor.
   function automatic longint floor_div(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   task automatic model_clear();
      mdl_gain = 16384;
      mdl_strength = 16384;
      mdl_taps = 256;
      mdl_channels = 1;
      mdl_noises = 1;
      for (int i = 0; i < 2*TAPS_MAX; i++) begin
         mdl_weight[i] = 0;
         mdl_history[i] = 0;
      end
      mdl_head[0] = 0;
      mdl_head[1] = 0;
      mdl_next_channel = 0;
   endtask

   task automatic model_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_SOURCE_GAIN:   mdl_gain = val;
         CSR_STRENGTH:      mdl_strength = val;
         CSR_TAP_COUNT:     mdl_taps = val[8:0];
         CSR_CHANNEL_COUNT: mdl_channels = val[1:0];
         CSR_NOISE_COUNT:   mdl_noises = val[2:0];
         default: ;
      endcase
   endtask

   // Works out the cleaned sample for one accepted beat and advances the state.
   task automatic predict_cleaned(input logic signed [SAMPLE_W-1:0] f [5],
                                  output cleaned_beat_type res);
      longint g, s, c, d, y, sum, acc, energy, err43, e20, step, p28, nw;
      int chans, ch, taps, n, head, idx, base;
      g = mdl_gain > 32768 ? 32768 : mdl_gain;
      s = mdl_strength > 32768 ? 32768 : mdl_strength;
      chans = mdl_channels < 1 ? 1 : (mdl_channels > 2 ? 2 : mdl_channels);
      ch = mdl_next_channel >= chans ? 0 : mdl_next_channel;
      d = longint'(f[0]);
      mdl_next_channel = (ch + 1 >= chans) ? 0 : ch + 1;
      if (s == 0) begin
         y = floor_div(d * g + 8192, 16384);
      end else begin
         taps = mdl_taps < 8 ? 8 : (mdl_taps > TAPS_MAX ? TAPS_MAX : mdl_taps);
         n = mdl_noises < 1 ? 1 : (mdl_noises > 4 ? 4 : mdl_noises);
         c = s > 24576 ? 24576 : s;
         base = ch * TAPS_MAX;
         head = mdl_head[ch] >= taps ? 0 : mdl_head[ch];
         sum = 0;
         acc = 0;
         energy = 0;
         for (int k = 0; k < n; k++) sum += longint'(f[1+k]);
         mdl_history[base+head] = floor_div(2*sum + n, 2*n);
         for (int k = 0; k < taps; k++) begin
            idx = head >= k ? head - k : head + taps - k;
            acc += mdl_weight[base+k] * mdl_history[base+idx];
            energy += mdl_history[base+idx] * mdl_history[base+idx];
         end
         // Weights adapt only when the window carries enough energy.
         if (energy >= ENERGY_EPS) begin
            err43 = d * (64'sd1 <<< 28) - acc;
            e20 = clip(floor_div(err43, 64'sd1 <<< 23), I32_MIN, I32_MAX);
            step = clip(floor_div(s * e20 * 65536, energy + ENERGY_EPS),
                        -STEP_CLIP, STEP_CLIP);
            for (int k = 0; k < taps; k++) begin
               idx = head >= k ? head - k : head + taps - k;
               nw = mdl_weight[base+k] + floor_div(step * mdl_history[base+idx], 512);
               mdl_weight[base+k] = clip(nw, I32_MIN, I32_MAX);
            end
         end
         p28 = floor_div(acc, 64'sd1 <<< 15);
         y = floor_div(d * g * 8192 - c * p28 + (64'sd1 <<< 26), 64'sd1 <<< 27);
         head++;
         mdl_head[ch] = head >= taps ? 0 : head;
      end
      res.cleaned = SAMPLE_W'(clip(y, -32768, 32767));
      res.channel = ch[0];
   endtask

   // -------------------------------------------------------------------------
   // Sample side. Fields are driven on the rising edge; a beat is taken at
   // the first edge where valid and ready are both high.
   // -------------------------------------------------------------------------
   task automatic send_beat(input logic signed [SAMPLE_W-1:0] f [5], input int gap,
                            input bit typed, input cleaned_beat_type want);
      cleaned_beat_type got;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.desired_sample <= f[0];
      req_bus.noise_a        <= f[1];
      req_bus.noise_b        <= f[2];
      req_bus.noise_c        <= f[3];
      req_bus.noise_d        <= f[4];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // The model runs for every beat so that its state stays in step, even
      // where the expected value was written into the table by hand.
      predict_cleaned(f, got);
      cleaned_queue.insert(cleaned_queue.size(), typed ? want : got);
   endtask

   // Lowers valid and waits until every outstanding result has been handed over.
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (cleaned_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      model_write(idx, val);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   int sender_burst = 0;

   function automatic int sender_gap();
      if (sender_burst > 0) begin
         sender_burst--;
         return 0;
      end
      if ($urandom_range(0, 29) == 0) sender_burst = $urandom_range(8, 30);
      return $urandom_range(0, 5);
   endfunction

   // -------------------------------------------------------------------------
   // Directed table.
   // -------------------------------------------------------------------------
   stim_row_type directed [$];

   task automatic add_row(stim_row_type r);
      directed.insert(directed.size(), r);
   endtask

   function automatic stim_row_type beat_row(int d, int na, int nb, int nc, int nd);
      stim_row_type r;
      r.kind = ROW_BEAT;
      r.index = CSR_SOURCE_GAIN;
      r.value = '0;
      r.fields[0] = SAMPLE_W'(d);
      r.fields[1] = SAMPLE_W'(na);
      r.fields[2] = SAMPLE_W'(nb);
      r.fields[3] = SAMPLE_W'(nc);
      r.fields[4] = SAMPLE_W'(nd);
      r.typed = 1'b0;
      r.want.cleaned = '0;
      r.want.channel = 1'b0;
      return r;
   endfunction

   function automatic stim_row_type known_row(int d, int na, int y, bit ch);
      stim_row_type r;
      r = beat_row(d, na, 0, 0, 0);
      r.typed = 1'b1;
      r.want.cleaned = SAMPLE_W'(y);
      r.want.channel = ch;
      return r;
   endfunction

   function automatic stim_row_type csr_row(logic [CSR_IDX_W-1:0] idx, int val);
      stim_row_type r;
      r = beat_row(0, 0, 0, 0, 0);
      r.kind = ROW_CSR;
      r.index = idx;
      r.value = CSR_DATA_W'(val);
      return r;
   endfunction

   task automatic build_table();
      // Fresh from reset: zero weights and zero history give back the source.
      add_row(known_row(32767, 0, 32767, 1'b0));
      add_row(beat_row(-32768, -32768, 32767, 32767, 32767));
      add_row(beat_row(0, 32767, -32768, 0, 0));
      add_row(beat_row(32767, 32767, 0, 0, 0));
      // Bypass with the gain at its extremes.
      add_row(csr_row(CSR_STRENGTH, 0));
      add_row(csr_row(CSR_SOURCE_GAIN, 32768));
      add_row(known_row(32767, 0, 32767, 1'b0));
      add_row(known_row(-32768, 0, -32768, 1'b0));
      add_row(known_row(-1, 0, -2, 1'b0));
      add_row(csr_row(CSR_SOURCE_GAIN, 0));
      add_row(known_row(32767, 0, 0, 1'b0));
      add_row(csr_row(CSR_SOURCE_GAIN, 65535));
      add_row(known_row(100, 0, 200, 1'b0));
      // Clamped strength, tap count below the floor, two channels, four noises.
      add_row(csr_row(CSR_SOURCE_GAIN, 16384));
      add_row(csr_row(CSR_STRENGTH, 65535));
      add_row(csr_row(CSR_TAP_COUNT, 0));
      add_row(csr_row(CSR_CHANNEL_COUNT, 2));
      add_row(csr_row(CSR_NOISE_COUNT, 4));
      add_row(beat_row(-32768, -32768, -32768, -32768, -32768));
      add_row(beat_row(32767, 32767, 32767, 32767, 32767));
      add_row(beat_row(12000, 32767, -32768, 1, -1));
      add_row(beat_row(-700, -3, 2, 0, 0));
      // Out-of-range counts, a tap count above the ceiling and spare indexes.
      add_row(csr_row(CSR_CHANNEL_COUNT, 0));
      add_row(csr_row(CSR_NOISE_COUNT, 0));
      add_row(csr_row(CSR_TAP_COUNT, 511));
      add_row(csr_row(CSR_SPARE_LO, 16'hFFFF));
      add_row(csr_row(CSR_SPARE_HI, 16'h1234));
      add_row(beat_row(20000, 30000, 5, 5, 5));
      add_row(beat_row(-20000, -30000, 5, 5, 5));
      add_row(csr_row(CSR_CHANNEL_COUNT, 3));
      add_row(csr_row(CSR_NOISE_COUNT, 7));
      add_row(csr_row(CSR_TAP_COUNT, 8));
      add_row(csr_row(CSR_STRENGTH, 1));
      add_row(beat_row(4000, 8000, -8000, 16000, -16000));
      add_row(beat_row(-4000, 100, 200, 300, 400));
      add_row(beat_row(30000, -20, 20, -20, 20));
      add_row(csr_row(CSR_STRENGTH, 24576));
      add_row(csr_row(CSR_NOISE_COUNT, 3));
      add_row(beat_row(15000, 20000, 21000, 22000, -32768));
      add_row(beat_row(-15000, -20000, -21000, -22000, 32767));
   endtask

   // Random register setting; small tap counts keep most phases fast.
   task automatic random_setting();
      int pick;
      pick = $urandom_range(0, 5);
      set_reg(CSR_SOURCE_GAIN,
              CSR_DATA_W'(pick == 0 ? 0 : pick == 1 ? 32768 : pick == 2 ? 65535
                          : $urandom_range(0, 32768)));
      pick = $urandom_range(0, 7);
      set_reg(CSR_STRENGTH,
              CSR_DATA_W'(pick == 0 ? 0 : pick == 1 ? 65535 : pick == 2 ? 24576
                          : $urandom_range(1, 32768)));
      pick = $urandom_range(0, 9);
      set_reg(CSR_TAP_COUNT,
              CSR_DATA_W'(pick == 0 ? 256 : pick == 1 ? $urandom_range(0, 511)
                          : $urandom_range(8, 40)));
      set_reg(CSR_CHANNEL_COUNT, CSR_DATA_W'($urandom_range(0, 3)));
      set_reg(CSR_NOISE_COUNT, CSR_DATA_W'($urandom_range(0, 7)));
      settings_used++;
   endtask

   // Mostly a source that carries a scaled copy of the noise, so the filter
   // has something to learn; the rest is unrelated or near-silent noise.
   task automatic random_fields(output logic signed [SAMPLE_W-1:0] f [5]);
      int mode;
      longint d;
      mode = $urandom_range(0, 9);
      for (int i = 1; i < 5; i++) f[i] = SAMPLE_W'($urandom());
      if (mode < 2) begin
         f[0] = SAMPLE_W'($urandom());
      end else if (mode == 2) begin
         for (int i = 1; i < 5; i++) f[i] = SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
         f[0] = SAMPLE_W'($urandom());
      end else begin
         d = longint'(f[1]) * 3 / 4 + longint'($urandom_range(0, 255)) - 128;
         f[0] = SAMPLE_W'(clip(d, -32768, 32767));
      end
   endtask

   // -------------------------------------------------------------------------
   // Stimulus sequence.
   // -------------------------------------------------------------------------
   initial begin
      logic signed [SAMPLE_W-1:0] f [5];
      cleaned_beat_type none;
      none.cleaned = '0;
      none.channel = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.desired_sample = '0;
      req_bus.noise_a = '0;
      req_bus.noise_b = '0;
      req_bus.noise_c = '0;
      req_bus.noise_d = '0;
      model_clear();
      build_table();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_CSR) begin
            drain();
            set_reg(directed[i].index, directed[i].value);
         end else begin
            send_beat(directed[i].fields, sender_gap(), directed[i].typed,
                      directed[i].want);
         end
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain();
         random_setting();
         // One phase starts with the result side held off for a long stretch.
         if (p == 2) hold_request = 1'b1;
         for (int b = 0; b < PHASE_BEATS; b++) begin
            random_fields(f);
            send_beat(f, sender_gap(), 1'b0, none);
         end
      end

      drain();
      repeat (20) @(posedge clock);
      $display("Summary: %0d cleaned beats checked over %0d random register settings,",
               beats_checked, settings_used);
      $display("including bypass, clamped registers, both channels and a long output stall.");
      if (errors == 0 && cleaned_queue.size() == 0) begin
         $display("tb_nlms_noise_canceller: clean");
      end else begin
         $display("tb_nlms_noise_canceller: errors");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Result side: random stalls, one long hold-off, and the scoreboard.
   // -------------------------------------------------------------------------
   initial begin
      int gap;
      int burst;
      cleaned_beat_type want;
      burst = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            gap = HOLD_CYCLES;
         end else if (burst > 0) begin
            burst--;
            gap = 0;
         end else begin
            if ($urandom_range(0, 29) == 0) burst = $urandom_range(8, 30);
            gap = $urandom_range(0, 5);
         end
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         if (cleaned_queue.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, cleaned_sample %0d channel %0d", $time,
                     rsp_bus.cleaned_sample, rsp_bus.sample_channel);
         end else begin
            want = cleaned_queue.pop_front();
            beats_checked++;
            if (rsp_bus.cleaned_sample !== want.cleaned) begin
               errors++;
               $display("%0t: cleaned_sample expected %0d, actual %0d", $time,
                        want.cleaned, rsp_bus.cleaned_sample);
            end
            if (rsp_bus.sample_channel !== want.channel) begin
               errors++;
               $display("%0t: sample_channel expected %0d, actual %0d", $time,
                        want.channel, rsp_bus.sample_channel);
            end
         end
      end
   end

   // The watchdog restarts whenever a beat moves on either channel.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
         $display("tb_nlms_noise_canceller: errors");
         $finish;
      end
   end

endmodule

FILE: nlms_noise_canceller.f
hdl/nlmsnc_pkg.sv
hdl/nlmsnc_if.sv
hdl/nlmsnc_ram.sv
hdl/nlmsnc_div.sv
hdl/nlms_noise_canceller.sv
tb/tb_nlms_noise_canceller.sv
